### design/tlvf_pkg.sv
// Shared types and constants for the TLV record type finder.
// No dependencies.
`timescale 1ns / 1ps

package tlvf_pkg;

   localparam int TYPE_BITS     = 6;
   localparam int LEN_CODE_BITS = 2;
   localparam int DATA_LEN_BITS = 24;
   localparam int RSP_OFS_BITS  = 16;
   localparam int RSP_DATA_BITS = 24;   // found + offset + overflow, padded to bytes

   typedef logic [TYPE_BITS-1:0] rec_kind_type;

   typedef struct packed {
      logic                    overflow;
      logic [RSP_OFS_BITS-1:0] match_offset;
      logic                    found;
   } result_type;

endpackage

### design/tlv_record_type_finder.sv
// A result is registered in the output buffer before it appears on rsp_.
// Throughput: one byte per cycle while req_tready is high; the two-entry result
// buffer lets bytes flow while a result waits and drops req_tready once full.
// Reset (synchronous, active high) clears the parse state, position, overflow
// flag, buffered results and wanted_type.
// Top level; depends on tlvf_pkg, tlvf_parser and tlvf_out_buf.
`timescale 1ns / 1ps

module tlv_record_type_finder #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // data_byte
   input  logic                          req_tlast,   // last_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // found [0], match_offset [16:1], overflow [17], zero pad [23:18]
   output logic [tlvf_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tlvf_pkg::TYPE_BITS-1:0] csr_data    // wanted_type
);
   import tlvf_pkg::*;

   rec_kind_type wanted_ff, wanted_in;
   logic         req_accept;
   logic         res_valid;
   result_type   res_data;
   result_type   rsp_res;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid & req_tready;
   assign wanted_in  = (csr_valid && csr_ready) ? csr_data : wanted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= '0;
      end else begin
         wanted_ff <= wanted_in;
      end
   end

   tlvf_parser #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(req_accept),
      .data_byte  (req_tdata),
      .last_byte  (req_tlast),
      .wanted_type(wanted_ff),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   tlvf_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  (res_data),
      .in_ready (req_tready),
      .out_valid(rsp_tvalid),
      .out_data (rsp_res),
      .out_ready(rsp_tready)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - $bits(result_type)){1'b0}}, rsp_res};

endmodule

### design/tlvf_parser.sv
// Record parser: phase, length and position tracking, one byte per accept.
// Depends on tlvf_pkg.
`timescale 1ns / 1ps

module tlvf_parser #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_accept,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  tlvf_pkg::rec_kind_type wanted_type,
   output logic                 res_valid,
   output tlvf_pkg::result_type res_data
);
   import tlvf_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [LEN_CODE_BITS-1:0] len_left_ff, len_left_in;
   logic [DATA_LEN_BITS-1:0] data_left_ff, data_left_in;
   logic [OFFSET_BITS-1:0]   pos_ff, pos_in;
   logic                     ovf_ff, ovf_in;
   logic                     done_ff, done_in;
   logic [31:0]              pos_wide;
   logic                     hit;

   assign pos_wide = 32'(pos_ff);

   always_comb begin
      phase_in     = phase_ff;
      len_left_in  = len_left_ff;
      data_left_in = data_left_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      done_in      = done_ff;
      hit          = 1'b0;
      res_valid    = 1'b0;
      res_data     = '0;
      if (byte_accept) begin
         if (!done_ff) begin
            unique case (phase_ff)
               PH_LENGTH: begin
                  data_left_in = {data_left_ff[DATA_LEN_BITS-9:0], data_byte};
                  len_left_in  = len_left_ff - 1'b1;
                  if (len_left_in == '0) begin
                     phase_in = (data_left_in == '0) ? PH_HEADER : PH_DATA;
                  end
               end
               PH_DATA: begin
                  data_left_in = data_left_ff - 1'b1;
                  if (data_left_in == '0) begin
                     phase_in = PH_HEADER;
                  end
               end
               default: begin
                  // unused phase code behaves as header
                  if (data_byte[7:2] == wanted_type) begin
                     hit     = 1'b1;
                     done_in = 1'b1;
                  end else if (data_byte[1:0] != '0) begin
                     phase_in     = PH_LENGTH;
                     len_left_in  = data_byte[1:0];
                     data_left_in = '0;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
            endcase
            res_valid             = hit | last_byte;
            res_data.found        = hit;
            res_data.match_offset = hit ? pos_wide[RSP_OFS_BITS-1:0] : '0;
            res_data.overflow     = ovf_ff;
         end
         if (last_byte) begin
            phase_in     = PH_HEADER;
            len_left_in  = '0;
            data_left_in = '0;
            pos_in       = '0;
            ovf_in       = 1'b0;
            done_in      = 1'b0;
         end else begin
            if (pos_ff == {OFFSET_BITS{1'b1}}) begin
               ovf_in = 1'b1;
            end
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         len_left_ff  <= '0;
         data_left_ff <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_left_ff  <= len_left_in;
         data_left_ff <= data_left_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         done_ff      <= done_in;
      end
   end

endmodule

### design/tlvf_out_buf.sv
// Result register with a skid stage, so the parser keeps taking bytes
// while a result waits. Depends on tlvf_pkg.
`timescale 1ns / 1ps

module tlvf_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  tlvf_pkg::result_type in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output tlvf_pkg::result_type out_data,
   input  logic                 out_ready
);
   import tlvf_pkg::*;

   logic       main_valid_ff, main_valid_in;
   result_type main_ff, main_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_data;
         end
      end else if (in_valid) begin
         // main is stalled; park the new request's result
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
